// ===== sv/point_rotation_about_pivot_assert.svh =====
// Assertion macros shared by the rotation block.
`ifndef POINT_ROTATION_ABOUT_PIVOT_ASSERT_SVH
`define POINT_ROTATION_ABOUT_PIVOT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PRAP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prap: assertion failed");
// next-cycle implication
`define PRAP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prap: assertion failed");
`else
`define PRAP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PRAP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/prap_pkg.sv =====
`timescale 1ns / 1ps
package prap_pkg;

  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;
  localparam int TRIG_W  = 18;

  typedef enum logic [1:0] {
    MODE_PLANAR = 2'd0,
    MODE_X      = 2'd1,
    MODE_Y      = 2'd2,
    MODE_Z      = 2'd3
  } mode_t;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_ANGLE   = 3'd1;
  localparam logic [2:0] REG_PIVOT_X = 3'd2;
  localparam logic [2:0] REG_PIVOT_Y = 3'd3;
  localparam logic [2:0] REG_PIVOT_Z = 3'd4;

  // pi in 60-bit fixed point and its split for the angle scaling
  localparam logic [63:0] PI_FIX     = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_HI      = PI_FIX >> 15;
  localparam logic [14:0] PI_LO      = PI_FIX[14:0];
  localparam logic [63:0] FIX_ONE    = 64'h1000000000000000;
  localparam logic [63:0] ROUND_HALF = 64'h0000080000000000;
  localparam logic [3:0]  TERM_LAST  = 4'd13;

  typedef struct packed {
    mode_t                      mode;
    logic [ANGLE_W-1:0]         angle;
    logic signed [COORD_W-1:0]  pivot_x;
    logic signed [COORD_W-1:0]  pivot_y;
    logic signed [COORD_W-1:0]  pivot_z;
  } cfg_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_t;

endpackage

// ===== sv/prap_trig.sv =====
`timescale 1ns / 1ps
`include "point_rotation_about_pivot_assert.svh"
module prap_trig (
  input  logic               clk,
  input  logic               rst,
  input  logic               restart,
  input  prap_pkg::cfg_t     cfg,
  output prap_pkg::trig_t    trig,
  output logic               busy
);

  typedef enum logic [8:0] {
    T_LOAD  = 9'b000000001,
    T_XMUL  = 9'b000000010,
    T_X2MUL = 9'b000000100,
    T_TSMUL = 9'b000001000,
    T_TSDIV = 9'b000010000,
    T_TCMUL = 9'b000100000,
    T_TCDIV = 9'b001000000,
    T_ROUND = 9'b010000000,
    T_IDLE  = 9'b100000000
  } state_t;

  state_t state;

  logic [1:0]   quad;
  logic [13:0]  r;
  logic [63:0]  opa, opb, x2, ts, tc, ss, sc;
  logic [3:0]   k;
  logic [127:0] acc;
  logic [1:0]   mcnt;
  logic [63:0]  dq;
  logic [9:0]   rem;
  logic [5:0]   dcnt;
  logic [9:0]   divisor;

  // shared 32x32 multiplier, four partial products per 64x64 product
  logic [63:0]  pp;
  logic [127:0] pp_ext;
  logic [6:0]   shamt;
  logic [127:0] mul_sum;
  logic [63:0]  prod_hi;
  logic         mul_done;

  assign pp = 64'(mcnt[1] ? opa[63:32] : opa[31:0]) * 64'(mcnt[0] ? opb[63:32] : opb[31:0]);
  assign pp_ext = {64'd0, pp};
  assign shamt = {mcnt[1] & mcnt[0], mcnt[1] ^ mcnt[0], 5'd0};
  assign mul_sum = acc + (pp_ext << shamt);
  assign prod_hi = mul_sum[123:60];
  assign mul_done = (mcnt == 2'd3);

  // restoring divider, one quotient bit per cycle
  logic [10:0] dt, dsub;
  logic        dge;
  logic [9:0]  rem_next;
  logic [63:0] dq_next;
  logic        div_done;

  assign dt = {rem, dq[63]};
  assign dsub = dt - {1'b0, divisor};
  assign dge = (dt >= {1'b0, divisor});
  assign rem_next = dge ? dsub[9:0] : dt[9:0];
  assign dq_next = {dq[62:0], dge};
  assign div_done = (dcnt == 6'd63);

  // series divisors (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  logic [4:0] k2;
  logic [9:0] div_s, div_c;
  assign k2 = {k, 1'b0};
  assign div_s = 10'(k2) * (10'(k2) + 10'd1);
  assign div_c = (10'(k2) - 10'd1) * 10'(k2);

  // angle remainder scaled to radians
  logic [28:0] rp;
  logic [63:0] x_val;
  assign rp = 29'(r) * 29'(prap_pkg::PI_LO);
  assign x_val = mul_sum[63:0] + 64'(rp[28:15]);

  // round to Q2.16, negative sums clamp to zero
  logic [63:0] sc_r, ss_r;
  logic signed [prap_pkg::TRIG_W-1:0] c_q, s_q;
  assign sc_r = sc + prap_pkg::ROUND_HALF;
  assign ss_r = ss + prap_pkg::ROUND_HALF;
  assign c_q = sc[63] ? '0 : $signed(sc_r[61:44]);
  assign s_q = ss[63] ? '0 : $signed(ss_r[61:44]);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= T_LOAD;
    end else begin
      unique case (state)
        T_LOAD: begin
          quad  <= cfg.angle[15:14];
          r     <= cfg.angle[13:0];
          opa   <= 64'(cfg.angle[13:0]);
          opb   <= prap_pkg::PI_HI;
          acc   <= '0;
          mcnt  <= '0;
          state <= T_XMUL;
        end
        T_XMUL: begin
          acc  <= mul_sum;
          mcnt <= mcnt + 2'd1;
          if (mul_done) begin
            opa   <= x_val;
            opb   <= x_val;
            acc   <= '0;
            state <= T_X2MUL;
          end
        end
        T_X2MUL: begin
          acc  <= mul_sum;
          mcnt <= mcnt + 2'd1;
          if (mul_done) begin
            x2    <= prod_hi;
            opb   <= prod_hi;
            ts    <= opa;
            ss    <= opa;
            tc    <= prap_pkg::FIX_ONE;
            sc    <= prap_pkg::FIX_ONE;
            k     <= 4'd1;
            acc   <= '0;
            state <= T_TSMUL;
          end
        end
        T_TSMUL: begin
          acc  <= mul_sum;
          mcnt <= mcnt + 2'd1;
          if (mul_done) begin
            dq      <= prod_hi;
            rem     <= '0;
            dcnt    <= '0;
            divisor <= div_s;
            state   <= T_TSDIV;
          end
        end
        T_TSDIV: begin
          dq   <= dq_next;
          rem  <= rem_next;
          dcnt <= dcnt + 6'd1;
          if (div_done) begin
            ts    <= dq_next;
            ss    <= k[0] ? ss - dq_next : ss + dq_next;
            opa   <= tc;
            opb   <= x2;
            acc   <= '0;
            state <= T_TCMUL;
          end
        end
        T_TCMUL: begin
          acc  <= mul_sum;
          mcnt <= mcnt + 2'd1;
          if (mul_done) begin
            dq      <= prod_hi;
            rem     <= '0;
            dcnt    <= '0;
            divisor <= div_c;
            state   <= T_TCDIV;
          end
        end
        T_TCDIV: begin
          dq   <= dq_next;
          rem  <= rem_next;
          dcnt <= dcnt + 6'd1;
          if (div_done) begin
            tc <= dq_next;
            sc <= k[0] ? sc - dq_next : sc + dq_next;
            if (k == prap_pkg::TERM_LAST) begin
              state <= T_ROUND;
            end else begin
              k     <= k + 4'd1;
              opa   <= ts;
              opb   <= x2;
              acc   <= '0;
              state <= T_TSMUL;
            end
          end
        end
        T_ROUND: begin
          // quadrant folding: swap and negate
          unique case (quad)
            2'd0: begin trig.cos_v <= c_q;  trig.sin_v <= s_q;  end
            2'd1: begin trig.cos_v <= -s_q; trig.sin_v <= c_q;  end
            2'd2: begin trig.cos_v <= -c_q; trig.sin_v <= -s_q; end
            default: begin trig.cos_v <= s_q; trig.sin_v <= -c_q; end
          endcase
          state <= T_IDLE;
        end
        T_IDLE: begin
          state <= T_IDLE;
        end
        default: begin
          state <= T_LOAD;
        end
      endcase
    end
  end

  assign busy = (state != T_IDLE);

  `PRAP_ASSERT_NXT(a_restart_busy, clk, rst, restart, busy)
  `PRAP_ASSERT_IMP(a_trig_range, clk, rst, !busy, (trig.cos_v <= 18'sd65536) && (trig.cos_v >= -18'sd65536) && (trig.sin_v <= 18'sd65536) && (trig.sin_v >= -18'sd65536))
  `PRAP_ASSERT_IMP(a_term_range, clk, rst, (state == T_TSMUL) || (state == T_TSDIV) || (state == T_TCMUL) || (state == T_TCDIV), (k >= 4'd1) && (k <= prap_pkg::TERM_LAST))

endmodule

// ===== sv/prap_pipe.sv =====
`timescale 1ns / 1ps
`include "point_rotation_about_pivot_assert.svh"
module prap_pipe (
  input  logic                                clk,
  input  logic                                rst,
  input  prap_pkg::cfg_t                      cfg,
  input  prap_pkg::trig_t                     trig,
  input  logic                                trig_busy,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [prap_pkg::COORD_W-1:0] in_x,
  input  logic signed [prap_pkg::COORD_W-1:0] in_y,
  input  logic signed [prap_pkg::COORD_W-1:0] in_z,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [prap_pkg::COORD_W-1:0] out_x,
  output logic signed [prap_pkg::COORD_W-1:0] out_y,
  output logic signed [prap_pkg::COORD_W-1:0] out_z,
  output logic                                out_last
);

  localparam logic signed [36:0] SAT_HI = 37'sd2147483647;
  localparam logic signed [36:0] SAT_LO = -37'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > SAT_HI) begin
      return 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance && !trig_busy;

  // stage 1: pick the rotating pair, subtract the pivot
  logic signed [31:0] sel_a, sel_b, sel_pa, sel_pb;
  always_comb begin
    unique case (cfg.mode)
      prap_pkg::MODE_X: begin
        sel_a = in_y; sel_b = in_z; sel_pa = cfg.pivot_y; sel_pb = cfg.pivot_z;
      end
      prap_pkg::MODE_Y: begin
        sel_a = in_z; sel_b = in_x; sel_pa = cfg.pivot_z; sel_pb = cfg.pivot_x;
      end
      default: begin
        sel_a = in_x; sel_b = in_y; sel_pa = cfg.pivot_x; sel_pb = cfg.pivot_y;
      end
    endcase
  end

  logic               v1;
  logic signed [32:0] da_s1, db_s1;
  logic signed [31:0] pa_s1, pb_s1, x_s1, y_s1, z_s1;
  logic               last_s1;

  // stage 2: four products
  logic               v2;
  logic signed [50:0] cda_s2, sdb_s2, sda_s2, cdb_s2;
  logic signed [31:0] pa_s2, pb_s2, x_s2, y_s2, z_s2;
  logic               last_s2;

  // stage 3: sums, floor shift, pivot back
  logic               v3;
  logic signed [36:0] ra_s3, rb_s3;
  logic signed [31:0] x_s3, y_s3, z_s3;
  logic               last_s3;

  logic signed [51:0] sum_a, sum_b;
  logic signed [35:0] sh_a, sh_b;
  assign sum_a = 52'(cda_s2) - 52'(sdb_s2);
  assign sum_b = 52'(sda_s2) + 52'(cdb_s2);
  assign sh_a  = 36'(sum_a >>> 16);
  assign sh_b  = 36'(sum_b >>> 16);

  logic signed [31:0] sat_a, sat_b;
  assign sat_a = sat32(ra_s3);
  assign sat_b = sat32(rb_s3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid && !trig_busy;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      da_s1   <= 33'(sel_a) - 33'(sel_pa);
      db_s1   <= 33'(sel_b) - 33'(sel_pb);
      pa_s1   <= sel_pa;
      pb_s1   <= sel_pb;
      x_s1    <= in_x;
      y_s1    <= in_y;
      z_s1    <= in_z;
      last_s1 <= in_last;

      cda_s2  <= 51'(trig.cos_v) * 51'(da_s1);
      sdb_s2  <= 51'(trig.sin_v) * 51'(db_s1);
      sda_s2  <= 51'(trig.sin_v) * 51'(da_s1);
      cdb_s2  <= 51'(trig.cos_v) * 51'(db_s1);
      pa_s2   <= pa_s1;
      pb_s2   <= pb_s1;
      x_s2    <= x_s1;
      y_s2    <= y_s1;
      z_s2    <= z_s1;
      last_s2 <= last_s1;

      ra_s3   <= 37'(sh_a) + 37'(pa_s2);
      rb_s3   <= 37'(sh_b) + 37'(pb_s2);
      x_s3    <= x_s2;
      y_s3    <= y_s2;
      z_s3    <= z_s2;
      last_s3 <= last_s2;

      // stage 4: saturate and put the pair back in place
      unique case (cfg.mode)
        prap_pkg::MODE_X: begin
          out_x <= x_s3; out_y <= sat_a; out_z <= sat_b;
        end
        prap_pkg::MODE_Y: begin
          out_x <= sat_b; out_y <= y_s3; out_z <= sat_a;
        end
        default: begin
          out_x <= sat_a; out_y <= sat_b; out_z <= z_s3;
        end
      endcase
      out_last <= last_s3;
    end
  end

  `PRAP_ASSERT_IMP(a_v2_from_v1, clk, rst, $rose(v2), $past(v1))
  `PRAP_ASSERT_NXT(a_busy_blocks, clk, rst, trig_busy && advance, !v1)
  `PRAP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_x))
  `PRAP_ASSERT_NXT(a_out_hold_yz, clk, rst, out_valid && !out_ready, $stable(out_y) && $stable(out_z))

endmodule

// ===== sv/point_rotation_about_pivot.sv =====
`timescale 1ns / 1ps
// Rotates a stream of Q16.16 points (x, y, z) by a configured angle about a
// configured pivot, either in the xy plane or about the x, y or z axis through
// the pivot; results saturate to 32-bit signed and the last flag rides along.
// One point is taken per cycle while in_ready is high (no output stall, no
// trig rebuild); it passes the stages pivot subtract, products, sum and shift,
// saturate into the output register; an output stall holds the whole pipeline.
// Cosine and sine are rebuilt after reset and after every write to the angle
// register by a sequencer that uses one 32x32 multiplier and a one-bit-per-cycle
// divider over 13 series terms, while in_ready stays low. Registers over APB at
// byte address 4*i: mode, angle, pivot_x, pivot_y, pivot_z.
module point_rotation_about_pivot (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [4:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [prap_pkg::COORD_W-1:0] in_x,
  input  logic signed [prap_pkg::COORD_W-1:0] in_y,
  input  logic signed [prap_pkg::COORD_W-1:0] in_z,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [prap_pkg::COORD_W-1:0] out_x,
  output logic signed [prap_pkg::COORD_W-1:0] out_y,
  output logic signed [prap_pkg::COORD_W-1:0] out_z,
  output logic                                out_last
);

  prap_pkg::cfg_t  cfg;
  prap_pkg::trig_t trig;
  logic            trig_busy;
  logic            wr;
  logic [2:0]      idx;
  logic            restart;

  assign pready  = 1'b1;
  assign idx     = paddr[4:2];
  assign wr      = psel && penable && pwrite && pready;
  assign restart = wr && (idx == prap_pkg::REG_ANGLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode    <= prap_pkg::MODE_PLANAR;
      cfg.angle   <= '0;
      cfg.pivot_x <= '0;
      cfg.pivot_y <= '0;
      cfg.pivot_z <= '0;
    end else if (wr) begin
      unique case (idx)
        prap_pkg::REG_MODE:    cfg.mode    <= prap_pkg::mode_t'(pwdata[1:0]);
        prap_pkg::REG_ANGLE:   cfg.angle   <= pwdata[15:0];
        prap_pkg::REG_PIVOT_X: cfg.pivot_x <= pwdata;
        prap_pkg::REG_PIVOT_Y: cfg.pivot_y <= pwdata;
        prap_pkg::REG_PIVOT_Z: cfg.pivot_z <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      prap_pkg::REG_MODE:    prdata = {30'd0, cfg.mode};
      prap_pkg::REG_ANGLE:   prdata = {16'd0, cfg.angle};
      prap_pkg::REG_PIVOT_X: prdata = cfg.pivot_x;
      prap_pkg::REG_PIVOT_Y: prdata = cfg.pivot_y;
      prap_pkg::REG_PIVOT_Z: prdata = cfg.pivot_z;
      default:               prdata = '0;
    endcase
  end

  prap_trig u_trig (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .cfg     (cfg),
    .trig    (trig),
    .busy    (trig_busy)
  );

  prap_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .trig      (trig),
    .trig_busy (trig_busy),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_last  (out_last)
  );

endmodule
